>>> rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types and constants of the compass heading CORDIC pipeline.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam int SMP_W  = 16;   // magnetometer sample width
	localparam int XY_W   = 21;   // CORDIC vector width, holds 4*|s|*gain
	localparam int ACC_W  = 18;   // angle accumulator, 65536 = 180 degrees
	localparam int OFF_W  = 9;    // quadrant offset width
	localparam int HDG_W  = 10;   // heading width
	localparam int PROD_W = 27;   // accumulator times degree scale
	localparam int FRAC_W = 16;   // angle fraction bits dropped after scaling
	localparam int LUT_N  = 16;   // arctangent table depth

	localparam logic [OFF_W-1:0] OFF_0   = OFF_W'(0);
	localparam logic [OFF_W-1:0] OFF_90  = OFF_W'(90);
	localparam logic [OFF_W-1:0] OFF_180 = OFF_W'(180);
	localparam logic [OFF_W-1:0] OFF_270 = OFF_W'(270);

	localparam logic signed [PROD_W-1:0] DEG_SCALE = PROD_W'(180);

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [HDG_W-1:0] hdg_t;

	// payload carried from stage to stage
	typedef struct packed {
		logic                     zx;    // X was zero: heading is the offset alone
		logic [OFF_W-1:0]         off;
		logic signed [XY_W-1:0]   x;
		logic signed [XY_W-1:0]   y;
		logic signed [ACC_W-1:0]  acc;
	} vec_t;

	function automatic logic signed [ACC_W-1:0] atan_lut(input logic [3:0] idx);
		logic [15:0] v;
		case (idx)
			4'd0:    v = 16'h4000;
			4'd1:    v = 16'h25C8;
			4'd2:    v = 16'h13F6;
			4'd3:    v = 16'h0A22;
			4'd4:    v = 16'h0516;
			4'd5:    v = 16'h028B;
			4'd6:    v = 16'h0145;
			4'd7:    v = 16'h00A2;
			4'd8:    v = 16'h0051;
			4'd9:    v = 16'h0029;
			4'd10:   v = 16'h0014;
			4'd11:   v = 16'h000A;
			4'd12:   v = 16'h0005;
			4'd13:   v = 16'h0003;
			4'd14:   v = 16'h0002;
			default: v = 16'h0001;
		endcase
		return $signed({{(ACC_W-16){1'b0}}, v});
	endfunction

endpackage

>>> rtl/chd_if.sv
// ----------------------------------------------------------------------------
// chd_if
// Valid/ready channels for magnetometer samples and heading results.
// ----------------------------------------------------------------------------
interface chd_in_if;
	logic                  valid;
	logic                  ready;
	logic signed [15:0]    mag_x;
	logic signed [15:0]    mag_y;

	modport source (output valid, output mag_x, output mag_y, input ready);
	modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

interface chd_out_if;
	logic                  valid;
	logic                  ready;
	logic signed [9:0]     heading_deg;

	modport source (output valid, output heading_deg, input ready);
	modport sink   (input valid, input heading_deg, output ready);
endinterface

>>> rtl/compass_heading_cordic.sv
// ----------------------------------------------------------------------------
// compass_heading_cordic
// Magnetometer X/Y sample to compass heading in degrees, CORDIC pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one signed 16-bit mag_x/mag_y pair per request; result
//   returns one signed 10-bit heading_deg per sample, in order.
//   The pipeline has one entry stage, one stage per CORDIC iteration, a
//   multiply stage and the output register. Throughput is one sample per
//   cycle while results are taken; each iteration has its own adder stage,
//   so nothing is shared between samples.
//   The whole pipeline advances together. While result holds a request that
//   is not taken, every stage holds and sample.ready is low; no data is lost
//   or repeated. With the output register empty or being taken, a new sample
//   is accepted in the same cycle.
//   Reset clears all valid bits; the pipeline is empty and ready right after.
// ----------------------------------------------------------------------------
module compass_heading_cordic #(
	parameter int ITERATIONS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	chd_in_if.sink    sample,
	chd_out_if.source result
);
	import chd_pkg::*;

	logic  en;
	logic  stg_v [0:ITERATIONS];
	vec_t  stg   [0:ITERATIONS];

	// advance the whole pipeline unless the output request is stalled
	assign en           = !result.valid || result.ready;
	assign sample.ready = en;

	chd_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d_v    (sample.valid),
		.sx     (sample.mag_x),
		.sy     (sample.mag_y),
		.q_v    (stg_v[0]),
		.q      (stg[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		chd_stage #(
			.K (i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_v    (stg_v[i]),
			.d      (stg[i]),
			.q_v    (stg_v[i+1]),
			.q      (stg[i+1])
		);
	end

	chd_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d_v    (stg_v[ITERATIONS]),
		.d      (stg[ITERATIONS]),
		.q_v    (result.valid),
		.q      (result.heading_deg)
	);

`ifndef ASSERT_OFF
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !sample.ready)
		else $error("sample accepted while result stalled");

	a_zero_x_offset: assert property (@(posedge clk) disable iff (!arst_n)
		stg_v[0] && stg[0].zx |-> (stg[0].off == OFF_90 || stg[0].off == OFF_270))
		else $error("zero X sample with wrong offset");

	a_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		stg_v[ITERATIONS] |-> !stg[ITERATIONS].x[XY_W-1])
		else $error("CORDIC X overflowed");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stg[ITERATIONS]) && $stable(stg_v[ITERATIONS]))
		else $error("pipeline moved during stall");
`endif

endmodule

>>> rtl/chd_prep.sv
// ----------------------------------------------------------------------------
// chd_prep
// Entry stage: takes magnitudes, scales by 4 and picks the quadrant offset.
// ----------------------------------------------------------------------------
module chd_prep (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          d_v,
	input  chd_pkg::smp_t sx,
	input  chd_pkg::smp_t sy,
	output logic          q_v,
	output chd_pkg::vec_t q
);
	import chd_pkg::*;

	logic [SMP_W:0]   ax;
	logic [SMP_W:0]   ay;
	logic             x_neg;
	logic             y_pos;
	vec_t             nxt;
	logic             v_s1;
	vec_t             pl_s1;

	always_comb begin
		x_neg = sx[SMP_W-1];
		y_pos = !sy[SMP_W-1] && (sy != '0);
		ax    = x_neg ? (SMP_W+1)'(-{sx[SMP_W-1], sx}) : {1'b0, sx};
		ay    = sy[SMP_W-1] ? (SMP_W+1)'(-{sy[SMP_W-1], sy}) : {1'b0, sy};
		nxt.zx  = (sx == '0);
		nxt.x   = $signed(XY_W'({ax, 2'b00}));
		nxt.y   = $signed(XY_W'({ay, 2'b00}));
		nxt.acc = '0;
		if (nxt.zx) begin
			nxt.off = y_pos ? OFF_270 : OFF_90;
		end else if (x_neg) begin
			nxt.off = y_pos ? OFF_180 : OFF_90;
		end else begin
			nxt.off = y_pos ? OFF_270 : OFF_0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= d_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= nxt;
		end
	end

	assign q_v = v_s1;
	assign q   = pl_s1;

endmodule

>>> rtl/chd_stage.sv
// ----------------------------------------------------------------------------
// chd_stage
// One CORDIC vectoring iteration with its pipeline register.
// ----------------------------------------------------------------------------
module chd_stage #(
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          d_v,
	input  chd_pkg::vec_t d,
	output logic          q_v,
	output chd_pkg::vec_t q
);
	import chd_pkg::*;

	localparam logic signed [ACC_W-1:0] ANG = atan_lut(4'(K));

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	vec_t                   nxt;
	logic                   v_s1;
	vec_t                   pl_s1;

	always_comb begin
		xs  = d.x >>> K;
		ys  = d.y >>> K;
		nxt = d;
		// rotate toward the X axis
		if (d.y > 0) begin
			nxt.x   = d.x + ys;
			nxt.y   = d.y - xs;
			nxt.acc = d.acc + ANG;
		end else begin
			nxt.x   = d.x - ys;
			nxt.y   = d.y + xs;
			nxt.acc = d.acc - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= d_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= nxt;
		end
	end

	assign q_v = v_s1;
	assign q   = pl_s1;

endmodule

>>> rtl/chd_scale.sv
// ----------------------------------------------------------------------------
// chd_scale
// Converts the angle to degrees and adds the quadrant offset (two stages).
// ----------------------------------------------------------------------------
module chd_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          d_v,
	input  chd_pkg::vec_t d,
	output logic          q_v,
	output chd_pkg::hdg_t q
);
	import chd_pkg::*;

	logic                     v_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [OFF_W-1:0]         off_s1;
	logic                     zx_s1;
	logic                     v_s2;
	hdg_t                     hdg_s2;
	logic [HDG_W-1:0]         ang;
	logic [HDG_W-1:0]         sum;

	always_comb begin
		// floor shift: keep the upper bits, wrap to the heading width
		ang = zx_s1 ? '0 : prod_s1[FRAC_W +: HDG_W];
		sum = HDG_W'(off_s1) + ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= d_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(d.acc) * DEG_SCALE;
			off_s1  <= d.off;
			zx_s1   <= d.zx;
			hdg_s2  <= $signed(sum);
		end
	end

	assign q_v = v_s2;
	assign q   = hdg_s2;

endmodule

>>> tb/compass_heading_cordic_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compass_heading_cordic_tb
// Drives magnetometer X/Y samples into the heading pipeline with random gaps
// and result back-pressure, and checks the results in order against its own
// CORDIC vectoring model or typed-in headings. A directed table covers
// the zero-X headings, zero Y, the most negative sample and the extremes.
// Random samples follow, with a long result stall and one full drain.
// ----------------------------------------------------------------------------
module compass_heading_cordic_tb;
	import chd_pkg::*;

	localparam int CORDIC_ITERS = 16;
	localparam int PIPE_LAT     = CORDIC_ITERS + 3;
	localparam int N_RANDOM     = 1080;
	localparam int LONG_HOLD    = 200;
	localparam int PRINT_MAX    = 40;
	localparam int N_DIRECTED   = 23;

	// arctangent of 2^-k, 65536 = 180 degrees
	localparam int ARCTAN [0:15] = '{
		16384, 9672, 5110, 2594, 1302, 651, 325, 162,
		81, 41, 20, 10, 5, 3, 2, 1
	};

	typedef struct packed {
		smp_t x;
		smp_t y;
		logic known;   // heading typed in below, not predicted
		hdg_t want;
	} dir_row_t;

	typedef struct {
		smp_t x;
		smp_t y;
		hdg_t want;
	} heading_exp_t;

	localparam dir_row_t DIR_TBL [0:N_DIRECTED-1] = '{
		'{16'sd0,      16'sd1,      1'b1, 10'sd270},
		'{16'sd0,      16'sd0,      1'b1, 10'sd90},
		'{16'sd0,     -16'sd1,      1'b1, 10'sd90},
		'{16'sd0,      16'sd32767,  1'b1, 10'sd270},
		'{16'sd0,      16'h8000,    1'b1, 10'sd90},
		'{16'sd1,      16'sd0,      1'b0, 10'sd0},
		'{-16'sd1,     16'sd0,      1'b0, 10'sd0},
		'{16'sd32767,  16'sd0,      1'b0, 10'sd0},
		'{16'h8000,    16'sd0,      1'b0, 10'sd0},
		'{16'sd32767,  16'sd32767,  1'b0, 10'sd0},
		'{16'h8000,    16'h8000,    1'b0, 10'sd0},
		'{16'h8000,    16'sd32767,  1'b0, 10'sd0},
		'{16'sd32767,  16'h8000,    1'b0, 10'sd0},
		'{16'sd1,      16'sd1,      1'b0, 10'sd0},
		'{-16'sd1,    -16'sd1,      1'b0, 10'sd0},
		'{16'sd1,     -16'sd1,      1'b0, 10'sd0},
		'{-16'sd1,     16'sd1,      1'b0, 10'sd0},
		'{16'sd1000,   16'sd1,      1'b0, 10'sd0},
		'{-16'sd1000, -16'sd1,      1'b0, 10'sd0},
		'{16'sd21845,  16'haaaa,    1'b0, 10'sd0},
		'{16'haaaa,    16'sd21845,  1'b0, 10'sd0},
		'{16'sd100,    16'sd32767,  1'b0, 10'sd0},
		'{16'h8000,    16'sd1,      1'b0, 10'sd0}
	};

	logic clk;
	logic arst_n;

	chd_in_if  smp_ch();
	chd_out_if hdg_ch();

	heading_exp_t pending_hdg[$];
	int           err_cnt      = 0;
	bit           tx_on        = 1'b0;
	bit           tx_calm      = 1'b0;
	bit           rx_calm      = 1'b0;
	bit           rx_long_hold = 1'b0;

	compass_heading_cordic #(
		.ITERATIONS(CORDIC_ITERS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(smp_ch.sink),
		.result(hdg_ch.source)
	);

	function automatic hdg_t predict_heading(input smp_t x, input smp_t y);
		longint sx, sy, vx, vy, nx, ny, acc, hd;
		int     k;
		sx = x;
		sy = y;
		if (sx == 0) begin
			hd = (sy > 0) ? 270 : 90;
		end else begin
			vx  = (sx < 0 ? -sx : sx) * 4;
			vy  = (sy < 0 ? -sy : sy) * 4;
			acc = 0;
			for (k = 0; k < CORDIC_ITERS; k++) begin
				// rotate toward the X axis, accumulate the angle
				if (vy > 0) begin
					nx  = vx + (vy >>> k);
					ny  = vy - (vx >>> k);
					acc = acc + ARCTAN[k];
				end else begin
					nx  = vx - (vy >>> k);
					ny  = vy + (vx >>> k);
					acc = acc - ARCTAN[k];
				end
				vx = nx;
				vy = ny;
			end
			hd = (acc * 180) >>> 16;
			if (sx < 0)
				hd = hd + ((sy > 0) ? 180 : 90);
			else
				hd = hd + ((sy > 0) ? 270 : 0);
		end
		return hd[HDG_W-1:0];
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic smp_t extreme_value();
		case ($urandom_range(0, 4))
			0:       return 16'h8000;
			1:       return 16'sd32767;
			2:       return -16'sd1;
			3:       return 16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input heading_exp_t e, input hdg_t got);
		err_cnt++;
		if (err_cnt <= PRINT_MAX)
			$display("%0t: %s: x=%0d y=%0d heading %0d, expected %0d",
				$realtime, what, e.x, e.y, got, e.want);
	endtask

	task automatic check_heading(input hdg_t got);
		heading_exp_t e;
		if (pending_hdg.size() == 0) begin
			e = '{x: '0, y: '0, want: '0};
			report_mismatch("heading with no request pending", e, got);
		end else begin
			e = pending_hdg.pop_front();
			if (got !== e.want)
				report_mismatch("wrong heading", e, got);
		end
	endtask

	// hold the request until taken, then record what it should produce
	task automatic push_sample(input smp_t x, input smp_t y, input logic known,
			input hdg_t want);
		heading_exp_t e;
		smp_ch.valid <= 1'b1;
		smp_ch.mag_x <= x;
		smp_ch.mag_y <= y;
		tx_on = 1'b1;
		do @(posedge clk); while (!smp_ch.ready);
		e.x    = x;
		e.y    = y;
		e.want = known ? want : predict_heading(x, y);
		pending_hdg.push_back(e);
	endtask

	task automatic drop_valid();
		if (tx_on) begin
			smp_ch.valid <= 1'b0;
			tx_on = 1'b0;
		end
	endtask

	task automatic idle_sender();
		int n;
		n = tx_calm ? 0 : gap_len();
		if (n > 0) begin
			drop_valid();
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_pipe();
		drop_valid();
		do @(posedge clk); while (pending_hdg.size() != 0);
	endtask

	task automatic pick_sample(output smp_t x, output smp_t y);
		case ($urandom_range(0, 9))
			6: begin
				x = smp_t'($urandom_range(0, 32)) - 16'sd16;
				y = smp_t'($urandom_range(0, 32)) - 16'sd16;
			end
			7: begin
				x = '0;
				y = smp_t'($urandom);
			end
			8: begin
				x = smp_t'($urandom);
				y = '0;
			end
			9: begin
				x = extreme_value();
				y = extreme_value();
			end
			default: begin
				x = smp_t'($urandom);
				y = smp_t'($urandom);
			end
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && hdg_ch.valid && hdg_ch.ready)
			check_heading(hdg_ch.heading_deg);
	end

	// result side: random stalls, calm stretches, one long hold
	initial begin : rx_side
		int hold;
		int cyc;
		hold = 0;
		cyc  = 0;
		hdg_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 200 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (rx_long_hold) begin
				rx_long_hold = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hdg_ch.ready <= 1'b0;
				hold--;
			end else begin
				hdg_ch.ready <= 1'b1;
				if (!rx_calm)
					hold = gap_len();
			end
		end
	end

	initial begin : tx_side
		smp_t x, y;
		int   i;
		smp_ch.valid <= 1'b0;
		smp_ch.mag_x <= '0;
		smp_ch.mag_y <= '0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			push_sample(DIR_TBL[i].x, DIR_TBL[i].y, DIR_TBL[i].known, DIR_TBL[i].want);
			idle_sender();
		end
		drain_pipe();

		for (i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			// stall results for a long stretch while requests keep coming
			if (i == 300)
				rx_long_hold = 1'b1;
			if (i == 700)
				drain_pipe();
			pick_sample(x, y);
			push_sample(x, y, 1'b0, '0);
			idle_sender();
		end
		drain_pipe();
		repeat (2 * PIPE_LAT) @(posedge clk);

		if (err_cnt == 0)
			$display("[compass_heading_cordic] OK");
		else
			$display("[compass_heading_cordic] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[compass_heading_cordic] ERROR");
		$finish;
	end

endmodule

>>> compass_heading_cordic.f
rtl/chd_pkg.sv
rtl/chd_if.sv
rtl/chd_prep.sv
rtl/chd_stage.sv
rtl/chd_scale.sv
rtl/compass_heading_cordic.sv
tb/compass_heading_cordic_tb.sv
